@@ rtl/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// Button press classifier package
// Widths, register indexes and reset values shared by the classifier files.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int NUM_BUTTONS = 5;
    localparam int BTN_W       = NUM_BUTTONS;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_LONG_PRESS = 2'd1,
        CFG_REPEAT_INT = 2'd2,
        CFG_REPEAT_EN  = 2'd3
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd30;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd800;
    localparam logic [CFG_W-1:0] REPEAT_INT_RST = 16'd200;
    localparam logic [BTN_W-1:0] REPEAT_EN_RST  = 5'd24;

endpackage

@@ rtl/bpc_scan_if.sv @@
// ----------------------------------------------------------------------------
// Button scan channel
// Carries one scan request: the active-low button levels and the time stamp.
// ----------------------------------------------------------------------------
interface bpc_scan_if;
    import bpc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BTN_W-1:0]  button_levels;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output button_levels, output now_ms, input ready);
    modport sink   (input valid, input button_levels, input now_ms, output ready);
endinterface

@@ rtl/bpc_event_if.sv @@
// ----------------------------------------------------------------------------
// Button event channel
// Carries one result request: the short, long and repeat event masks of a scan.
// ----------------------------------------------------------------------------
interface bpc_event_if;
    import bpc_pkg::*;

    logic             valid;
    logic             ready;
    logic [BTN_W-1:0] short_press_mask;
    logic [BTN_W-1:0] long_press_mask;
    logic [BTN_W-1:0] repeat_mask;

    modport source (output valid, output short_press_mask, output long_press_mask,
                    output repeat_mask, input ready);
    modport sink   (input valid, input short_press_mask, input long_press_mask,
                    input repeat_mask, output ready);
endinterface

@@ rtl/button_press_classifier.sv @@
// ----------------------------------------------------------------------------
// Button press classifier
// Turns periodic button scans into short, long and auto-repeat event masks.
// ----------------------------------------------------------------------------
// Each request on i_scan carries the active-low levels of all buttons and a
// free-running millisecond time stamp. For every scan exactly one request
// leaves on o_event with the short-press, long-press and repeat masks.
// A scan is captured in an input register and classified as it leaves it,
// when the per-button state is updated and the masks enter the output
// register. One scan is accepted in every cycle while the output is taken.
// When the receiver stalls, the output register holds its request, one more
// scan waits in the input register, and i_scan.ready then goes low.
// Reset clears both registers, all held and long-press flags and loads the
// default thresholds. The user must write thresholds through i_cfg_we,
// i_cfg_idx, i_cfg_data while no scan is in flight; the block does not check.
// ----------------------------------------------------------------------------
module button_press_classifier (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bpc_pkg::CFG_W-1:0]       i_cfg_data,
    bpc_scan_if.sink                        i_scan,
    bpc_event_if.source                     o_event
);
    import bpc_pkg::*;

    logic [CFG_W-1:0]  r_debounce;
    logic [CFG_W-1:0]  r_long_press;
    logic [CFG_W-1:0]  r_repeat_int;
    logic [BTN_W-1:0]  r_repeat_en;

    logic              r_in_vld;
    logic [BTN_W-1:0]  r_in_levels;
    logic [TIME_W-1:0] r_in_now;

    logic [NUM_BUTTONS-1:0] r_held;
    logic [NUM_BUTTONS-1:0] r_long_sent;
    logic [TIME_W-1:0]      r_press_time [NUM_BUTTONS];
    logic [TIME_W-1:0]      r_last_rep   [NUM_BUTTONS];

    logic [NUM_BUTTONS-1:0] n_held;
    logic [NUM_BUTTONS-1:0] n_long_sent;
    logic [TIME_W-1:0]      n_press_time [NUM_BUTTONS];
    logic [TIME_W-1:0]      n_last_rep   [NUM_BUTTONS];
    logic [TIME_W-1:0]      w_hold       [NUM_BUTTONS];
    logic [TIME_W-1:0]      w_since_rep  [NUM_BUTTONS];

    logic              r_out_vld;
    logic [BTN_W-1:0]  r_short;
    logic [BTN_W-1:0]  r_long;
    logic [BTN_W-1:0]  r_rep;
    logic [BTN_W-1:0]  n_short;
    logic [BTN_W-1:0]  n_long;
    logic [BTN_W-1:0]  n_rep;

    logic w_advance;
    logic w_accept;

    assign w_advance     = r_in_vld && (!r_out_vld || o_event.ready);
    assign i_scan.ready  = !r_in_vld || w_advance;
    assign w_accept      = i_scan.valid && i_scan.ready;

    assign o_event.valid            = r_out_vld;
    assign o_event.short_press_mask = r_short;
    assign o_event.long_press_mask  = r_long;
    assign o_event.repeat_mask      = r_rep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= DEBOUNCE_RST;
            r_long_press <= LONG_PRESS_RST;
            r_repeat_int <= REPEAT_INT_RST;
            r_repeat_en  <= REPEAT_EN_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DEBOUNCE:   r_debounce   <= i_cfg_data;
                CFG_LONG_PRESS: r_long_press <= i_cfg_data;
                CFG_REPEAT_INT: r_repeat_int <= i_cfg_data;
                CFG_REPEAT_EN:  r_repeat_en  <= i_cfg_data[BTN_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (w_advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_levels <= i_scan.button_levels;
            r_in_now    <= i_scan.now_ms;
        end
    end

    always_comb begin
        n_held      = r_held;
        n_long_sent = r_long_sent;
        n_short     = '0;
        n_long      = '0;
        n_rep       = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            n_press_time[i] = r_press_time[i];
            n_last_rep[i]   = r_last_rep[i];
            w_hold[i]       = r_in_now - r_press_time[i];
            w_since_rep[i]  = r_in_now - r_last_rep[i];
            if (!r_in_levels[i] && !r_held[i]) begin
                n_held[i]       = 1'b1;
                n_long_sent[i]  = 1'b0;
                n_press_time[i] = r_in_now;
                n_last_rep[i]   = r_in_now;
            end else if (r_in_levels[i] && r_held[i]) begin
                n_held[i]  = 1'b0;
                n_short[i] = (w_hold[i] >= TIME_W'(r_debounce)) && !r_long_sent[i];
            end else if (!r_in_levels[i] && r_held[i]) begin
                if ((w_hold[i] >= TIME_W'(r_long_press)) && !r_long_sent[i]) begin
                    n_long_sent[i] = 1'b1;
                    n_long[i]      = 1'b1;
                end
                if (r_repeat_en[i] && n_long_sent[i]
                        && (w_since_rep[i] >= TIME_W'(r_repeat_int))) begin
                    n_rep[i]      = 1'b1;
                    n_last_rep[i] = r_in_now;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_long_sent <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_press_time[i] <= '0;
                r_last_rep[i]   <= '0;
            end
        end else if (w_advance) begin
            r_held      <= n_held;
            r_long_sent <= n_long_sent;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_press_time[i] <= n_press_time[i];
                r_last_rep[i]   <= n_last_rep[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_advance) begin
            r_out_vld <= 1'b1;
        end else if (o_event.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_short <= n_short;
            r_long  <= n_long;
            r_rep   <= n_rep;
        end
    end

`ifndef SYNTHESIS
    a_short_not_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_short & r_long) == '0))
        else $error("short and long press reported for the same button");

    a_long_marks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (((r_long | r_rep) & ~r_long_sent) == '0))
        else $error("long or repeat event without long-press flag");

    a_short_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_short & r_held) == '0))
        else $error("short press reported while button still held");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_vld)
        else $error("classified scan did not reach the output register");
`endif

endmodule
